>>> hw/rtl/ntis_pkg.sv
// ----------------------------------------------------------------------------
// Nearest time index search package
// Shared field widths, transaction codes and payload types of the block.
// ----------------------------------------------------------------------------
package ntis_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned TIME_W = 32;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] entry_time;
    logic [TIME_W-1:0] query_time;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic             table_unset;
  } out_t;

endpackage

>>> hw/rtl/nearest_time_index_search.sv
// ----------------------------------------------------------------------------
// Nearest time index search
// Keeps a table of time stamps in one synchronous memory and answers
// queries with the index of the nearest entry.
//
// Both channels are valid/ready. An input transaction with kind load writes
// one table entry; it produces no output transaction.
// A query is answered by one output transaction. The search runs one memory
// read per cycle: first entry, last entry, hint entry, entry after the hint,
// then for each binary search step the midpoint and possibly one neighbor.
// The single read port of the table memory sets the pace of the search, and
// a query on an empty table is answered without a table read. Input is
// accepted only while no query is being searched or waiting to be answered.
// A finished result waits in the output register; loads and the next query
// are accepted while it waits, and a later result waits until the receiver
// takes the earlier.
// Reset empties the table and clears the hint; the memory contents are not
// cleared, and entries are defined once written.
// ----------------------------------------------------------------------------
module nearest_time_index_search #(
  parameter int unsigned TABLE_DEPTH = ntis_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = ntis_pkg::TIME_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ntis_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ntis_pkg::out_t out_data_o
);

  import ntis_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIRST = 8'b00000010,
    S_LAST  = 8'b00000100,
    S_HINT  = 8'b00001000,
    S_HINT1 = 8'b00010000,
    S_MID   = 8'b00100000,
    S_NBR   = 8'b01000000,
    S_RESP  = 8'b10000000
  } state_e;

  state_e                state_q, state_d;
  logic [TIME_WIDTH-1:0] t_q, t_d;
  logic [TIME_WIDTH-1:0] v_q, v_d;
  logic [CW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         hi_q, hi_d;
  logic [AW-1:0]         mid_q, mid_d;
  logic                  dir_hi_q, dir_hi_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         hint_q, hint_d;
  logic [AW-1:0]         res_q, res_d;
  logic                  unset_q, unset_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_data_q, out_data_d;

  logic [TIME_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [TIME_WIDTH-1:0] wr_data;

  logic                  in_fire;
  logic                  finish;
  logic [AW-1:0]         fin_idx;
  logic                  step;
  logic [CW-1:0]         lo_n, hi_n;
  logic [AW-1:0]         mid_n;
  logic [AW-1:0]         last_idx;
  logic [CW-1:0]         new_count;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  assign last_idx = AW'(count_q - CW'(1));
  assign new_count = CW'(in_data_i.entry_index) + CW'(1);

  assign wr_en = in_fire && (in_data_i.kind == KIND_LOAD)
                 && (32'(in_data_i.entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(in_data_i.entry_index);
  assign wr_data = TIME_WIDTH'(in_data_i.entry_time);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    t_d = t_q;
    v_d = v_q;
    lo_d = lo_q;
    hi_d = hi_q;
    mid_d = mid_q;
    dir_hi_d = dir_hi_q;
    count_d = count_q;
    hint_d = hint_q;
    res_d = res_q;
    unset_d = unset_q;
    rd_addr = mid_q;
    finish = 1'b0;
    fin_idx = '0;
    step = 1'b0;
    lo_n = lo_q;
    hi_n = hi_q;
    mid_n = mid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d = out_data_q;

    if (wr_en && (new_count > count_q)) begin
      count_d = new_count;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_data_i.kind == KIND_QUERY)) begin
          t_d = TIME_WIDTH'(in_data_i.query_time);
          if (count_q == '0) begin
            res_d = '0;
            unset_d = 1'b1;
            state_d = S_RESP;
          end else begin
            unset_d = 1'b0;
            rd_addr = '0;
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (t_q <= rd_data_q) begin
          finish = 1'b1;
          fin_idx = '0;
        end else begin
          rd_addr = last_idx;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (t_q >= rd_data_q) begin
          finish = 1'b1;
          fin_idx = last_idx;
        end else begin
          rd_addr = hint_q;
          state_d = S_HINT;
        end
      end
      S_HINT: begin
        if (t_q == rd_data_q) begin
          finish = 1'b1;
          fin_idx = hint_q;
        end else if ((CW'(hint_q) + CW'(1)) < count_q) begin
          rd_addr = AW'(hint_q + AW'(1));
          state_d = S_HINT1;
        end else begin
          step = 1'b1;
          lo_n = '0;
          hi_n = count_q;
        end
      end
      S_HINT1: begin
        if (t_q == rd_data_q) begin
          finish = 1'b1;
          fin_idx = AW'(hint_q + AW'(1));
        end else begin
          step = 1'b1;
          lo_n = '0;
          hi_n = count_q;
        end
      end
      S_MID: begin
        v_d = rd_data_q;
        if (t_q == rd_data_q) begin
          finish = 1'b1;
          fin_idx = mid_q;
        end else if (t_q < rd_data_q) begin
          if (mid_q != '0) begin
            rd_addr = AW'(mid_q - AW'(1));
            dir_hi_d = 1'b0;
            state_d = S_NBR;
          end else begin
            step = 1'b1;
            hi_n = CW'(mid_q);
          end
        end else begin
          if ((CW'(mid_q) + CW'(1)) < count_q) begin
            rd_addr = AW'(mid_q + AW'(1));
            dir_hi_d = 1'b1;
            state_d = S_NBR;
          end else begin
            step = 1'b1;
            lo_n = CW'(mid_q) + CW'(1);
          end
        end
      end
      S_NBR: begin
        if (!dir_hi_q) begin
          if (t_q > rd_data_q) begin
            finish = 1'b1;
            fin_idx = ((t_q - rd_data_q) >= (v_q - t_q)) ? mid_q : AW'(mid_q - AW'(1));
          end else begin
            step = 1'b1;
            hi_n = CW'(mid_q);
          end
        end else begin
          if (t_q < rd_data_q) begin
            finish = 1'b1;
            fin_idx = ((t_q - v_q) >= (rd_data_q - t_q)) ? AW'(mid_q + AW'(1)) : mid_q;
          end else begin
            step = 1'b1;
            lo_n = CW'(mid_q) + CW'(1);
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d.nearest_index = IDX_W'(res_q);
          out_data_d.table_unset = unset_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (step) begin
      lo_d = lo_n;
      hi_d = hi_n;
      if (lo_n < hi_n) begin
        mid_n = AW'((SW'(lo_n) + SW'(hi_n)) >> 1);
        mid_d = mid_n;
        rd_addr = mid_n;
        state_d = S_MID;
      end else begin
        finish = 1'b1;
        fin_idx = mid_q;
      end
    end

    if (finish) begin
      res_d = fin_idx;
      hint_d = fin_idx;
      state_d = S_RESP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      hint_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hint_q <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    v_q <= v_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    mid_q <= mid_d;
    dir_hi_q <= dir_hi_d;
    res_q <= res_d;
    unset_q <= unset_d;
    out_data_q <= out_data_d;
  end

endmodule

>>> test/nearest_index_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest time index search monitor
// Watches both channels of the search block. It keeps its own copy of the
// time stamp table and the hint, works out the answer to every accepted query
// and compares each output transaction field by field with the oldest
// outstanding answer.
// ----------------------------------------------------------------------------
module nearest_index_monitor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ntis_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ntis_pkg::out_t out_data_i,
  output int unsigned    errors_o,
  output int unsigned    pending_o
);
  import ntis_pkg::*;

  logic [TIME_W-1:0] stamp_tbl [TABLE_DEPTH_DEF];
  int unsigned       stamp_count;
  int unsigned       last_hit;
  logic              loaded;
  int unsigned       errs;
  out_t              answer_q [$];

  function automatic int unsigned nearest_of(input logic [TIME_W-1:0] t);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [TIME_W-1:0] v;
    logic [TIME_W-1:0] nb;
    n = stamp_count;
    lo = 0;
    hi = n;
    mid = 0;
    if (t <= stamp_tbl[0]) return 0;
    if (t >= stamp_tbl[n-1]) return n - 1;
    if (last_hit < n && t == stamp_tbl[last_hit]) return last_hit;
    if (last_hit + 1 < n && t == stamp_tbl[last_hit+1]) return last_hit + 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      v = stamp_tbl[mid];
      if (t == v) return mid;
      if (t < v) begin
        if (mid > 0) begin
          nb = stamp_tbl[mid-1];
          if (t > nb) return ((t - nb) >= (v - t)) ? mid : mid - 1;
        end
        hi = mid;
      end else begin
        if (mid + 1 < n) begin
          nb = stamp_tbl[mid+1];
          if (t < nb) return ((t - v) >= (nb - t)) ? mid + 1 : mid;
        end
        lo = mid + 1;
      end
    end
    return mid;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t        want;
    int unsigned idx;
    if (!rst_ni) begin
      answer_q.delete();
      stamp_count = 0;
      last_hit = 0;
      loaded = 1'b0;
      errs = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: nearest_index %0d table_unset %0d",
                 out_data_i.nearest_index, out_data_i.table_unset);
          errs++;
        end else begin
          want = answer_q.pop_front();
          if (out_data_i.nearest_index !== want.nearest_index) begin
            $error("nearest_index: expected %0d, actual %0d",
                   want.nearest_index, out_data_i.nearest_index);
            errs++;
          end
          if (out_data_i.table_unset !== want.table_unset) begin
            $error("table_unset: expected %0d, actual %0d",
                   want.table_unset, out_data_i.table_unset);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_LOAD) begin
          idx = 32'(in_data_i.entry_index);
          stamp_tbl[idx] = in_data_i.entry_time;
          if (idx + 1 > stamp_count) stamp_count = idx + 1;
          loaded = 1'b1;
        end else begin
          if (!loaded || stamp_count == 0) begin
            want.nearest_index = '0;
            want.table_unset = 1'b1;
          end else begin
            last_hit = nearest_of(in_data_i.query_time);
            want.nearest_index = last_hit[IDX_W-1:0];
            want.table_unset = 1'b0;
          end
          answer_q = {answer_q, want};
        end
      end
    end
    errors_o <= errs;
    pending_o <= answer_q.size();
  end

endmodule

>>> test/tb_nearest_time_index_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest time index search testbench
// Loads sorted, partly sorted and scrambled time stamp tables of growing size
// and queries them with exact entries, exact midpoints, values next to
// midpoints, values beyond both ends and random times. The sender works in
// bursts and the receiver stalls on its own pattern; the monitor checks every
// answer.
// ----------------------------------------------------------------------------
module tb_nearest_time_index_search;
  import ntis_pkg::*;

  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned open_queries;

  logic [TIME_W-1:0] shadow [TABLE_DEPTH_DEF];
  int unsigned       shadow_n;
  int unsigned       sent;
  int unsigned       burst_left;
  int unsigned       walk;
  int unsigned       ready_left = 0;
  int unsigned       cycles = 0;

  nearest_time_index_search u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  nearest_index_monitor u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (fail_count),
    .pending_o   (open_queries)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b1;
        ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      end
    end else begin
      ready_left--;
    end
  end

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  task automatic push_item(input in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic load_entry(input int unsigned idx, input logic [TIME_W-1:0] stamp);
    in_t item;
    item.kind = KIND_LOAD;
    item.entry_index = idx[IDX_W-1:0];
    item.entry_time = stamp;
    item.query_time = $urandom;
    push_item(item);
    shadow[idx] = stamp;
    if (idx + 1 > shadow_n) shadow_n = idx + 1;
  endtask

  task automatic ask(input logic [TIME_W-1:0] t);
    in_t item;
    item.kind = KIND_QUERY;
    item.entry_index = IDX_W'($urandom);
    item.entry_time = $urandom;
    item.query_time = t;
    push_item(item);
  endtask

  task automatic rewrite_sorted();
    int unsigned       i;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] step_max;
    case ($urandom_range(0, 2))
      0: begin
        stamp = $urandom_range(0, 20);
        step_max = 3;
      end
      1: begin
        stamp = $urandom;
        step_max = 1000;
      end
      default: begin
        stamp = $urandom_range(0, 1) ? '0 : $urandom_range(0, 65535);
        step_max = 32'hFFFF_FFFF / shadow_n;
      end
    endcase
    for (i = 0; i < shadow_n; i++) begin
      load_entry(i, stamp);
      stamp = sat_add(stamp, $urandom_range(0, step_max));
    end
  endtask

  task automatic extend_table();
    int unsigned       k;
    logic [TIME_W-1:0] stamp;
    k = $urandom_range(1, 4);
    while (k > 0 && shadow_n < TABLE_DEPTH_DEF) begin
      if ($urandom_range(0, 9) == 0) stamp = $urandom;
      else stamp = sat_add(shadow[shadow_n-1], $urandom >> $urandom_range(4, 31));
      load_entry(shadow_n, stamp);
      k--;
    end
  endtask

  task automatic ask_mix(input int unsigned count);
    int unsigned       q;
    int unsigned       i;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] t;
    for (q = 0; q < count; q++) begin
      i = $urandom_range(0, shadow_n - 1);
      a = shadow[i];
      b = (i + 1 < shadow_n) ? shadow[i+1] : a;
      case ($urandom_range(0, 7))
        0: t = a;
        1: t = a + (b - a) / 2;
        2: t = a + (b - a) / 2 + 1;
        3: t = a + (b - a) / 2 - 1;
        4: t = a + $urandom_range(0, b - a);
        5: t = $urandom_range(0, 1) ? $urandom_range(0, shadow[0]) :
               $urandom_range(shadow[shadow_n-1], 32'hFFFF_FFFF);
        6: t = $urandom;
        default: begin
          walk = (walk + 1) % shadow_n;
          t = shadow[walk];
        end
      endcase
      ask(t);
    end
  endtask

  initial begin : stimulus
    int unsigned roll;
    in_valid <= 1'b0;
    in_data <= '0;
    rst_n <= 1'b0;
    shadow_n = 0;
    sent = 0;
    burst_left = 0;
    walk = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ask(32'h0000_0000);
    ask(32'hFFFF_FFFF);
    load_entry(0, 32'd0);
    ask(32'd0);
    ask(32'd50);
    load_entry(1, 32'd100);
    load_entry(2, 32'd200);
    load_entry(3, 32'd300);
    load_entry(4, 32'hFFFF_FFFF);
    ask(32'd0);
    ask(32'hFFFF_FFFF);
    ask(32'd250);
    ask(32'd149);
    ask(32'd150);
    ask(32'd200);
    ask(32'd200);
    ask(32'd300);
    load_entry(2, 32'd5);
    ask(32'd150);
    ask(32'h7FFF_FFFF);

    while (sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 40 && shadow_n < TABLE_DEPTH_DEF) extend_table();
      else if (roll < 65) rewrite_sorted();
      else if (roll < 80) load_entry($urandom_range(0, shadow_n - 1), $urandom);
      ask_mix($urandom_range(4, 24));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (open_queries != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ntis_pkg.sv
hw/rtl/nearest_time_index_search.sv
test/nearest_index_monitor.sv
test/tb_nearest_time_index_search.sv
